>>> hw/rtl/pisfd_pkg.sv
// ----------------------------------------------------------------------------
// pisfd_pkg - shared types, constants and helpers
// Register map, config bundle, Q16.16 saturation and clamp functions used by
// the PID datapath and its helper units.
// ----------------------------------------------------------------------------
`default_nettype none

package pisfd_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Serial divider: 64-bit dividend magnitude, 17-bit divisor
  localparam int DIV_W    = 64;
  localparam int DVSR_W   = 17;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Config port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_ALPHA = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_THRESH  = 4'd7;

  // Opcodes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Q16.16 constants
  localparam logic [16:0] Q_ONE       = 17'd65536;
  localparam logic [16:0] DT_FALLBACK = 17'd66;   // 0.001 s

  // Register reset values
  localparam logic [30:0] RST_PROP_GAIN   = 31'd65536;
  localparam logic [30:0] RST_INTEG_GAIN  = 31'd32768;
  localparam logic [30:0] RST_DERIV_GAIN  = 31'd0;
  localparam logic [30:0] RST_INTEG_LIMIT = 31'd6553600;
  localparam logic [30:0] RST_DRIVE_LIMIT = 31'd5242880;
  localparam logic [16:0] RST_DERIV_ALPHA = 17'd19661;
  localparam logic [16:0] RST_STEP_TIME   = 17'd1311;
  localparam logic [30:0] RST_SEP_THRESH  = 31'd1310720;

  typedef struct packed {
    logic [30:0] prop_gain;
    logic [30:0] integ_gain;
    logic [30:0] deriv_gain;
    logic [30:0] integ_limit;
    logic [30:0] drive_limit;
    logic [16:0] deriv_alpha;
    logic [16:0] step_time;
    logic [30:0] separation_threshold;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp to +/- lim; lim is a 31-bit magnitude
  function automatic logic signed [31:0] clamp_mag(input logic signed [PROD_W-1:0] x,
                                                   input logic [30:0] lim);
    logic signed [PROD_W-1:0] lim_w;
    logic signed [31:0]       r;
    lim_w = $signed({35'b0, lim});
    if (x > lim_w) begin
      r = $signed({1'b0, lim});
    end else if (x < -lim_w) begin
      r = -$signed({1'b0, lim});
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pisfd_regs.sv
// ----------------------------------------------------------------------------
// pisfd_regs - configuration register file
// Eight gain, limit and timing registers written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module pisfd_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pisfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pisfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pisfd_pkg::cfg_t                           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain            <= pisfd_pkg::RST_PROP_GAIN;
      cfg.integ_gain           <= pisfd_pkg::RST_INTEG_GAIN;
      cfg.deriv_gain           <= pisfd_pkg::RST_DERIV_GAIN;
      cfg.integ_limit          <= pisfd_pkg::RST_INTEG_LIMIT;
      cfg.drive_limit          <= pisfd_pkg::RST_DRIVE_LIMIT;
      cfg.deriv_alpha          <= pisfd_pkg::RST_DERIV_ALPHA;
      cfg.step_time            <= pisfd_pkg::RST_STEP_TIME;
      cfg.separation_threshold <= pisfd_pkg::RST_SEP_THRESH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pisfd_pkg::REG_PROP_GAIN:   cfg.prop_gain            <= cfg_data[30:0];
        pisfd_pkg::REG_INTEG_GAIN:  cfg.integ_gain           <= cfg_data[30:0];
        pisfd_pkg::REG_DERIV_GAIN:  cfg.deriv_gain           <= cfg_data[30:0];
        pisfd_pkg::REG_INTEG_LIMIT: cfg.integ_limit          <= cfg_data[30:0];
        pisfd_pkg::REG_DRIVE_LIMIT: cfg.drive_limit          <= cfg_data[30:0];
        pisfd_pkg::REG_DERIV_ALPHA: cfg.deriv_alpha          <= cfg_data[16:0];
        pisfd_pkg::REG_STEP_TIME:   cfg.step_time            <= cfg_data[16:0];
        pisfd_pkg::REG_SEP_THRESH:  cfg.separation_threshold <= cfg_data[30:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pisfd_mul.sv
// ----------------------------------------------------------------------------
// pisfd_mul - shared signed multiplier
// 33x33 signed product, registered; result valid in the cycle after issue.
// ----------------------------------------------------------------------------
`default_nettype none

module pisfd_mul (
  input  wire logic                                   clk,
  input  wire logic signed [pisfd_pkg::MUL_W-1:0]     a,
  input  wire logic signed [pisfd_pkg::MUL_W-1:0]     b,
  output logic signed [pisfd_pkg::PROD_W-1:0]         prod
);

  always_ff @(posedge clk) begin
    prod <= pisfd_pkg::PROD_W'(a) * pisfd_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

>>> hw/rtl/pisfd_div.sv
// ----------------------------------------------------------------------------
// pisfd_div - serial restoring divider
// Signed 64-bit dividend over unsigned 17-bit divisor, one quotient bit per
// cycle. Returns quotient magnitude and sign (truncation toward zero).
// ----------------------------------------------------------------------------
`default_nettype none

module pisfd_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [pisfd_pkg::DIV_W-1:0]    dividend,
  input  wire logic [pisfd_pkg::DVSR_W-1:0]          divisor,
  output pisfd_pkg::div_status_t                     status,
  output logic [pisfd_pkg::DIV_W-1:0]                quot_mag,
  output logic                                       quot_neg
);

  localparam int W  = pisfd_pkg::DIV_W;
  localparam int DW = pisfd_pkg::DVSR_W;
  localparam int CW = pisfd_pkg::DIV_CNT_W;

  logic [CW-1:0] count;
  logic [W-1:0]  dq;        // dividend bits shift out, quotient bits shift in
  logic [DW-1:0] rem;
  logic [DW-1:0] dvsr;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [W-1:0]  dividend_mag;

  assign dividend_mag = dividend[W-1] ? W'(-dividend) : W'(dividend);
  assign trial    = {rem, dq[W-1]};
  assign ge       = trial >= {1'b0, dvsr};
  assign rem_next = ge ? DW'(trial - {1'b0, dvsr}) : trial[DW-1:0];
  assign quot_mag = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
      count       <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        count       <= '0;
      end else if (status.busy) begin
        count <= count + 1'b1;
        if (count == CW'(W - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq       <= dividend_mag;
      rem      <= '0;
      dvsr     <= divisor;
      quot_neg <= dividend[W-1];
    end else if (status.busy) begin
      dq  <= {dq[W-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pid_integral_separation_filtered_d.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_filtered_d - Q16.16 PID step controller
// Integral separation, conditional-integration anti-windup, low-pass
// filtered derivative, clamped output. Sequencer around one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): opcode and error_sample. A step
//   transaction yields one drive/clamped result; a clear transaction zeroes
//   prev_error, the integral and the filtered derivative and yields nothing.
//   Output channel (out_valid/out_stall): one result register; a new item
//   is accepted while a finished result still waits there.
//   Config channel (cfg_valid/cfg_ready): index and data, always ready;
//   write only while the block is idle.
//   Sequence: a step runs through the states P, TI, INC, ACC, I, D, DST,
//   DW, FA, FB, FS and OUT; in DW it waits on the bit-serial divider for
//   the derivative (64 quotient bits), and the other steps work around the
//   shared 33x33 multiplier. in_stall is high for the whole step, so a new
//   step is not taken before the last one is back in idle; a clear is taken
//   in idle and leaves the sequencer there. If the receiver stalls, the
//   sequencer holds in its final step until the output register frees up.
//   Reset (rst, synchronous): registers to defaults, state zero, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_integral_separation_filtered_d (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 opcode,
  input  wire logic signed [31:0]                   error_sample,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [31:0]                        drive,
  output logic                                      clamped,
  // config channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pisfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pisfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MW = pisfd_pkg::MUL_W;
  localparam int PW = pisfd_pkg::PROD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P    = 4'd1;
  localparam logic [3:0] S_TI   = 4'd2;
  localparam logic [3:0] S_INC  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_I    = 4'd5;
  localparam logic [3:0] S_D    = 4'd6;
  localparam logic [3:0] S_DST  = 4'd7;
  localparam logic [3:0] S_DW   = 4'd8;
  localparam logic [3:0] S_FA   = 4'd9;
  localparam logic [3:0] S_FB   = 4'd10;
  localparam logic [3:0] S_FS   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  pisfd_pkg::cfg_t        cfg;
  pisfd_pkg::div_status_t div_status;

  logic [3:0]               state;
  logic signed [31:0]       e_reg;
  logic signed [31:0]       p_reg;
  logic signed [31:0]       i_reg;
  logic signed [31:0]       raw_d;
  logic                     win;
  logic signed [PW-1:0]     fsum;

  logic signed [31:0]       prev_error;
  logic signed [31:0]       integ_acc;
  logic signed [31:0]       filtered_deriv;

  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [PW-1:0]     prod;

  logic                     div_start;
  logic [pisfd_pkg::DIV_W-1:0] quot_mag;
  logic                     quot_neg;

  logic                     in_acc;
  logic                     out_free;
  logic [16:0]              dt;
  logic [16:0]              alpha;
  logic [16:0]              one_m_alpha;
  logic signed [PW-1:0]     prod_sh;
  logic signed [31:0]       prod_q;
  logic signed [32:0]       e_ext;
  logic [32:0]              e_mag;
  logic                     sep_ok;
  logic signed [31:0]       trial_sat;
  logic signed [33:0]       dlim_s;
  logic                     win_next;
  logic signed [31:0]       acc_new;
  logic signed [32:0]       diff;
  logic signed [31:0]       raw_d_next;
  logic signed [31:0]       filt_next;
  logic signed [PW-1:0]     drive_sum;
  logic signed [PW-1:0]     dlim_w;

  pisfd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pisfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pisfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[pisfd_pkg::DIV_W-1:0]),
    .divisor  (dt),
    .status   (div_status),
    .quot_mag (quot_mag),
    .quot_neg (quot_neg)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_DST);

  assign dt          = (cfg.step_time == '0) ? pisfd_pkg::DT_FALLBACK : cfg.step_time;
  assign alpha       = (cfg.deriv_alpha > pisfd_pkg::Q_ONE) ? pisfd_pkg::Q_ONE
                                                            : cfg.deriv_alpha;
  assign one_m_alpha = 17'(pisfd_pkg::Q_ONE - alpha);

  // arithmetic shift is floor for Q16.16 products
  assign prod_sh = prod >>> 16;
  assign prod_q  = pisfd_pkg::sat32(prod_sh);

  assign e_ext  = 33'(e_reg);
  assign e_mag  = e_reg[31] ? 33'(-e_ext) : 33'(e_ext);
  assign sep_ok = e_mag < {2'b0, cfg.separation_threshold};

  // anti-windup window: sat(P + Ki*I_old) strictly inside +/- drive_limit
  assign trial_sat = pisfd_pkg::sat32(PW'(p_reg) + PW'(prod_q));
  assign dlim_s    = $signed({3'b0, cfg.drive_limit});
  assign win_next  = (34'(trial_sat) < dlim_s) && (34'(trial_sat) > -dlim_s);

  assign acc_new = pisfd_pkg::clamp_mag(
                     PW'(pisfd_pkg::sat32(PW'(integ_acc) + prod_sh)), cfg.integ_limit);

  assign diff = 33'(e_reg) - 33'(prev_error);

  always_comb begin
    if (!quot_neg) begin
      raw_d_next = (quot_mag > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : $signed(quot_mag[31:0]);
    end else begin
      raw_d_next = (quot_mag > 64'h8000_0000) ? 32'sh80000000
                                              : $signed(32'(~quot_mag[31:0] + 32'd1));
    end
  end

  assign filt_next = pisfd_pkg::sat32((fsum + prod) >>> 16);

  assign drive_sum = PW'(p_reg) + PW'(i_reg) + PW'(filtered_deriv);
  assign dlim_w    = $signed({35'b0, cfg.drive_limit});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_P:  begin mul_a = $signed({2'b0, cfg.prop_gain});  mul_b = 33'(e_reg);          end
      S_TI: begin mul_a = $signed({2'b0, cfg.integ_gain}); mul_b = 33'(integ_acc);      end
      S_INC: begin mul_a = 33'(e_reg);                     mul_b = $signed({16'b0, dt}); end
      S_I:  begin mul_a = $signed({2'b0, cfg.integ_gain}); mul_b = 33'(integ_acc);      end
      S_D:  begin mul_a = $signed({2'b0, cfg.deriv_gain}); mul_b = diff;                end
      S_FA: begin mul_a = $signed({16'b0, alpha});         mul_b = 33'(raw_d);          end
      S_FB: begin mul_a = $signed({16'b0, one_m_alpha});   mul_b = 33'(filtered_deriv); end
      default: ;
    endcase
  end

  // sequencer and stored controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      prev_error     <= '0;
      integ_acc      <= '0;
      filtered_deriv <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode == pisfd_pkg::OP_CLEAR) begin
              prev_error     <= '0;
              integ_acc      <= '0;
              filtered_deriv <= '0;
            end else begin
              state <= S_P;
            end
          end
        end
        S_P:   state <= S_TI;
        S_TI:  state <= S_INC;
        S_INC: state <= S_ACC;
        S_ACC: begin
          if (!sep_ok) begin
            integ_acc <= '0;
          end else if (win) begin
            integ_acc <= acc_new;
          end
          state <= S_I;
        end
        S_I:   state <= S_D;
        S_D:   state <= S_DST;
        S_DST: state <= S_DW;
        S_DW: begin
          if (div_status.done) begin
            state <= S_FA;
          end
        end
        S_FA:  state <= S_FB;
        S_FB:  state <= S_FS;
        S_FS: begin
          filtered_deriv <= filt_next;
          prev_error     <= e_reg;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      e_reg <= error_sample;
    end
    if (state == S_TI) begin
      p_reg <= prod_q;
    end
    if (state == S_INC) begin
      win <= win_next;
    end
    if (state == S_D) begin
      i_reg <= prod_q;
    end
    if (state == S_DW && div_status.done) begin
      raw_d <= raw_d_next;
    end
    if (state == S_FB) begin
      fsum <= prod;
    end
    if (state == S_OUT && out_free) begin
      drive   <= pisfd_pkg::clamp_mag(drive_sum, cfg.drive_limit);
      clamped <= (drive_sum > dlim_w) || (drive_sum < -dlim_w);
    end
  end

`ifndef NO_ASSERTIONS
  a_rst_idle: assert property (@(posedge clk)
    rst |=> (state == S_IDLE) && !out_valid)
    else $error("sequencer not idle after reset");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == pisfd_pkg::OP_CLEAR) |=>
      (integ_acc == '0) && (prev_error == '0) && (filtered_deriv == '0) && (state == S_IDLE))
    else $error("clear did not zero the controller state");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DW) |-> (div_status.busy || div_status.done))
    else $error("waiting on an idle divider");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_valid && (state == S_IDLE))
    else $error("result not loaded into the output register");
`endif

endmodule

`default_nettype wire

>>> tb/pid_integral_separation_filtered_d_tb.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_filtered_d_tb - self-checking testbench
// Drives error samples and clear commands into the Q16.16 PID step block,
// predicts each drive/clamped result with an in-bench fixed-point model and
// compares in order. Covers register extremes, masking, back-pressure and
// random settings with random idling on both channels.
// ----------------------------------------------------------------------------

module pid_integral_separation_filtered_d_tb;

  localparam int     CLK_PERIOD  = 8;
  localparam int     STEP_SETTLE = 100;
  localparam int     LONG_HOLD   = 400;
  localparam int     DRAIN_LIMIT = 20000;
  localparam int     NUM_REGS    = 8;
  localparam int     NUM_PHASES  = 12;
  localparam int     PHASE_ITEMS = 120;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] drive;
    logic               clamped;
  } drive_result_t;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic                             opcode;
  logic signed [31:0]               error_sample;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [31:0]               drive;
  logic                             clamped;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [pisfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pisfd_pkg::CFG_DATA_W-1:0] cfg_data;

  // predicted register file and controller state
  pisfd_pkg::cfg_t    pid_regs;
  logic signed [31:0] prev_err;
  logic signed [31:0] integ_acc;
  logic signed [31:0] filt_deriv;
  drive_result_t      drive_exp_q[$];

  logic [31:0] reg_img [NUM_REGS];
  bit          quiet;
  bit          hold_req;
  int          mismatches;
  int          results_checked;
  int          steps_sent;
  int          clears_sent;
  int          cfg_writes;
  int          blocked_cycles;
  int          holds_done;

  pid_integral_separation_filtered_d u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .error_sample (error_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive        (drive),
    .clamped      (clamped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 2000000);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [31:0] sat_q(input longint x);
    if (x > Q_MAX) return 32'sh7fffffff;
    if (x < Q_MIN) return 32'sh80000000;
    return 32'(x);
  endfunction

  function automatic logic signed [31:0] mag_clamp(input longint x, input logic [30:0] lim);
    longint bound;
    bound = longint'(lim);
    if (x > bound) return 32'(bound);
    if (x < -bound) return 32'(-bound);
    return 32'(x);
  endfunction

  // Q16.16 gain times value, floor shift, saturate
  function automatic logic signed [31:0] gain_mul(input logic [30:0] gain,
                                                  input logic signed [31:0] v);
    return sat_q((longint'(gain) * longint'(v)) >>> 16);
  endfunction

  function automatic void pid_predict_step(input logic signed [31:0] err);
    longint             e;
    longint             mag;
    longint             lim;
    longint             sum;
    logic [16:0]        dt;
    logic [16:0]        alpha;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] trial;
    logic signed [31:0] raw_d;
    drive_result_t      res;
    e     = longint'(err);
    lim   = longint'(pid_regs.drive_limit);
    dt    = (pid_regs.step_time == '0) ? pisfd_pkg::DT_FALLBACK : pid_regs.step_time;
    alpha = (pid_regs.deriv_alpha > pisfd_pkg::Q_ONE) ? pisfd_pkg::Q_ONE
                                                      : pid_regs.deriv_alpha;
    p_term = gain_mul(pid_regs.prop_gain, err);
    mag = (e < 0) ? -e : e;
    if (mag < longint'(pid_regs.separation_threshold)) begin
      trial = sat_q(longint'(p_term) + longint'(gain_mul(pid_regs.integ_gain, integ_acc)));
      // conditional integration: only while strictly inside the drive window
      if (longint'(trial) < lim && longint'(trial) > -lim) begin
        integ_acc = mag_clamp(sat_q(longint'(integ_acc) + ((e * longint'(dt)) >>> 16)),
                              pid_regs.integ_limit);
      end
    end else begin
      integ_acc = '0;
    end
    i_term = gain_mul(pid_regs.integ_gain, integ_acc);
    raw_d = sat_q((longint'(pid_regs.deriv_gain) * (e - longint'(prev_err))) / longint'(dt));
    filt_deriv = sat_q((longint'(alpha) * longint'(raw_d) +
                        (longint'(pisfd_pkg::Q_ONE) - longint'(alpha)) *
                        longint'(filt_deriv)) >>> 16);
    prev_err = err;
    sum = longint'(p_term) + longint'(i_term) + longint'(filt_deriv);
    res.clamped = (sum > lim) || (sum < -lim);
    res.drive   = mag_clamp(sum, pid_regs.drive_limit);
    drive_exp_q.push_back(res);
  endfunction

  // ------------------------------------------------------- scoreboard/monitor

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      pid_regs.prop_gain            = pisfd_pkg::RST_PROP_GAIN;
      pid_regs.integ_gain           = pisfd_pkg::RST_INTEG_GAIN;
      pid_regs.deriv_gain           = pisfd_pkg::RST_DERIV_GAIN;
      pid_regs.integ_limit          = pisfd_pkg::RST_INTEG_LIMIT;
      pid_regs.drive_limit          = pisfd_pkg::RST_DRIVE_LIMIT;
      pid_regs.deriv_alpha          = pisfd_pkg::RST_DERIV_ALPHA;
      pid_regs.step_time            = pisfd_pkg::RST_STEP_TIME;
      pid_regs.separation_threshold = pisfd_pkg::RST_SEP_THRESH;
      prev_err   = '0;
      integ_acc  = '0;
      filt_deriv = '0;
      drive_exp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (drive_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d: result with nothing pending, drive %0d clamped %0b",
                     mismatches, drive, clamped);
        end else begin
          want = drive_exp_q.pop_front();
          if (drive !== want.drive || clamped !== want.clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: drive exp %0d got %0d, clamped exp %0b got %0b",
                       mismatches, want.drive, drive, want.clamped, clamped);
          end
        end
      end
      if (in_valid && in_stall && out_valid && out_stall) blocked_cycles++;
      if (in_valid && !in_stall) begin
        if (opcode == pisfd_pkg::OP_CLEAR) begin
          clears_sent++;
          prev_err   = '0;
          integ_acc  = '0;
          filt_deriv = '0;
        end else begin
          steps_sent++;
          pid_predict_step(error_sample);
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          pisfd_pkg::REG_PROP_GAIN:   pid_regs.prop_gain            = cfg_data[30:0];
          pisfd_pkg::REG_INTEG_GAIN:  pid_regs.integ_gain           = cfg_data[30:0];
          pisfd_pkg::REG_DERIV_GAIN:  pid_regs.deriv_gain           = cfg_data[30:0];
          pisfd_pkg::REG_INTEG_LIMIT: pid_regs.integ_limit          = cfg_data[30:0];
          pisfd_pkg::REG_DRIVE_LIMIT: pid_regs.drive_limit          = cfg_data[30:0];
          pisfd_pkg::REG_DERIV_ALPHA: pid_regs.deriv_alpha          = cfg_data[16:0];
          pisfd_pkg::REG_STEP_TIME:   pid_regs.step_time            = cfg_data[16:0];
          pisfd_pkg::REG_SEP_THRESH:  pid_regs.separation_threshold = cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // receiver: random stall bursts, plus a long counted hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        holds_done++;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_sample(input logic op, input logic signed [31:0] err);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    error_sample <= err;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic cfg_write(input logic [pisfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // clears issue no result, so settle for a full step after the queue drains
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_exp_q.size() != 0) @(posedge clk);
    repeat (STEP_SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input bit junk);
    wait_idle();
    cfg_write(pisfd_pkg::REG_PROP_GAIN,   reg_img[pisfd_pkg::REG_PROP_GAIN]);
    cfg_write(pisfd_pkg::REG_INTEG_GAIN,  reg_img[pisfd_pkg::REG_INTEG_GAIN]);
    cfg_write(pisfd_pkg::REG_DERIV_GAIN,  reg_img[pisfd_pkg::REG_DERIV_GAIN]);
    cfg_write(pisfd_pkg::REG_INTEG_LIMIT, reg_img[pisfd_pkg::REG_INTEG_LIMIT]);
    cfg_write(pisfd_pkg::REG_DRIVE_LIMIT, reg_img[pisfd_pkg::REG_DRIVE_LIMIT]);
    cfg_write(pisfd_pkg::REG_DERIV_ALPHA, reg_img[pisfd_pkg::REG_DERIV_ALPHA]);
    cfg_write(pisfd_pkg::REG_STEP_TIME,   reg_img[pisfd_pkg::REG_STEP_TIME]);
    cfg_write(pisfd_pkg::REG_SEP_THRESH,  reg_img[pisfd_pkg::REG_SEP_THRESH]);
    // unmapped index must be ignored
    if (junk)
      cfg_write(pisfd_pkg::CFG_IDX_W'($urandom_range(NUM_REGS,
                                                     (1 << pisfd_pkg::CFG_IDX_W) - 1)),
                $urandom());
  endtask

  // 31-bit register value; top data bit is junk that must be masked
  function automatic logic [31:0] pick_wide(input int unsigned typical);
    logic [30:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = 31'($urandom());
      default: v = 31'($urandom_range(0, typical));
    endcase
    return {1'($urandom()), v};
  endfunction

  function automatic logic [31:0] pick_narrow();
    logic [16:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = pisfd_pkg::Q_ONE;
      2:       v = 17'($urandom_range(65537, 131071));
      3:       v = 17'($urandom_range(1, 64));
      default: v = 17'($urandom_range(0, 65536));
    endcase
    return {15'($urandom()), v};
  endfunction

  task automatic randomize_regs();
    reg_img[pisfd_pkg::REG_PROP_GAIN]   = pick_wide(1 << 18);
    reg_img[pisfd_pkg::REG_INTEG_GAIN]  = pick_wide(1 << 18);
    reg_img[pisfd_pkg::REG_DERIV_GAIN]  = pick_wide(1 << 16);
    reg_img[pisfd_pkg::REG_INTEG_LIMIT] = pick_wide(1 << 24);
    reg_img[pisfd_pkg::REG_DRIVE_LIMIT] = pick_wide(1 << 24);
    reg_img[pisfd_pkg::REG_DERIV_ALPHA] = pick_narrow();
    reg_img[pisfd_pkg::REG_STEP_TIME]   = pick_narrow();
    reg_img[pisfd_pkg::REG_SEP_THRESH]  = pick_wide(1 << 22);
  endtask

  // mostly errors around the separation band so the integral gets exercised
  function automatic logic signed [31:0] pick_error();
    longint     span;
    longint     v;
    bit [63:0]  wide;
    int         sel;
    span = longint'(pid_regs.separation_threshold) +
           longint'(pid_regs.separation_threshold >> 2) + 1;
    wide = {$urandom(), $urandom()};
    sel  = $urandom_range(0, 99);
    if (sel < 55) begin
      v = longint'(wide % 64'(2 * span + 1)) - span;
    end else if (sel < 70) begin
      v = longint'($urandom_range(0, 131072)) - 65536;
    end else if (sel < 85) begin
      v = longint'($signed($urandom()));
    end else if (sel < 95) begin
      case ($urandom_range(0, 6))
        0:       v = Q_MAX;
        1:       v = Q_MIN;
        2:       v = longint'(pid_regs.separation_threshold);
        3:       v = -longint'(pid_regs.separation_threshold);
        4:       v = longint'(pid_regs.separation_threshold) - 1;
        5:       v = 1 - longint'(pid_regs.separation_threshold);
        default: v = 0;
      endcase
    end else begin
      v = longint'(prev_err);
    end
    return sat_q(v);
  endfunction

  task automatic send_random_items(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 24) == 0) send_sample(pisfd_pkg::OP_CLEAR, $urandom());
      else send_sample(pisfd_pkg::OP_STEP, pick_error());
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_directed_extremes();
    send_sample(pisfd_pkg::OP_STEP, 32'sd0);
    send_sample(pisfd_pkg::OP_STEP, 32'sd1);
    send_sample(pisfd_pkg::OP_STEP, -32'sd1);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
    send_sample(pisfd_pkg::OP_STEP, 32'sh80000000);
    // separation threshold edges
    send_sample(pisfd_pkg::OP_STEP, $signed({1'b0, pisfd_pkg::RST_SEP_THRESH}) - 1);
    send_sample(pisfd_pkg::OP_STEP, $signed({1'b0, pisfd_pkg::RST_SEP_THRESH}));
    send_sample(pisfd_pkg::OP_STEP, -$signed({1'b0, pisfd_pkg::RST_SEP_THRESH}));
    send_sample(pisfd_pkg::OP_STEP, 1 - $signed({1'b0, pisfd_pkg::RST_SEP_THRESH}));
    send_sample(pisfd_pkg::OP_CLEAR, 32'sh7fffffff);
    send_sample(pisfd_pkg::OP_STEP, 32'sd65536);
  endtask

  task automatic test_config_extremes();
    // everything zero: fallback step time, empty drive window, integral always cleared
    foreach (reg_img[r]) reg_img[r] = '0;
    program_regs(1'b0);
    send_sample(pisfd_pkg::OP_STEP, 32'sd1);
    send_sample(pisfd_pkg::OP_STEP, -32'sd1);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
    // all ones: masking, alpha above one, saturating products
    foreach (reg_img[r]) reg_img[r] = '1;
    program_regs(1'b1);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
    send_sample(pisfd_pkg::OP_STEP, 32'sh80000000);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
    // huge derivative with zero step time and half filter
    reg_img[pisfd_pkg::REG_DERIV_GAIN]  = 32'h7fffffff;
    reg_img[pisfd_pkg::REG_STEP_TIME]   = '0;
    reg_img[pisfd_pkg::REG_DERIV_ALPHA] = 32'd32768;
    reg_img[pisfd_pkg::REG_PROP_GAIN]   = 32'd65536;
    program_regs(1'b0);
    send_sample(pisfd_pkg::OP_STEP, 32'sh80000000);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
    send_sample(pisfd_pkg::OP_CLEAR, 32'sd0);
    send_sample(pisfd_pkg::OP_STEP, 32'sh7fffffff);
  endtask

  task automatic test_backpressure();
    randomize_regs();
    program_regs(1'b0);
    hold_req = 1'b1;
    send_random_items(8);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      randomize_regs();
      program_regs($urandom_range(0, 2) == 0);
      send_random_items(PHASE_ITEMS);
    end
  endtask

  task automatic test_no_idle();
    wait_idle();
    quiet = 1'b1;
    randomize_regs();
    program_regs(1'b0);
    send_random_items(110);
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = pisfd_pkg::OP_STEP;
    error_sample = '0;
    cfg_valid    = 1'b0;
    cfg_index    = pisfd_pkg::REG_PROP_GAIN;
    cfg_data     = '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    test_no_idle();

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (drive_exp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (STEP_SETTLE) @(posedge clk);
    if (drive_exp_q.size() != 0) begin
      $display("%0d expected results never arrived", drive_exp_q.size());
      mismatches += drive_exp_q.size();
    end

    $display("Covered %0d step and %0d clear transactions, %0d results checked, %0d reg writes",
             steps_sent, clears_sent, results_checked, cfg_writes);
    $display("Long output holds: %0d, cycles with block full and input held off: %0d, errors: %0d",
             holds_done, blocked_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> pid_integral_separation_filtered_d.f
hw/rtl/pisfd_pkg.sv
hw/rtl/pisfd_regs.sv
hw/rtl/pisfd_mul.sv
hw/rtl/pisfd_div.sv
hw/rtl/pid_integral_separation_filtered_d.sv
tb/pid_integral_separation_filtered_d_tb.sv
